FILE: rtl/mat_pkg.sv
package mat_pkg;

    localparam int HOMING_SAMPLES = 20;

    localparam int RAW_W      = 32;
    localparam int V_W        = 34;
    localparam int REM_W      = V_W + 1;
    localparam int WRAP_W     = 29;
    localparam int DELTA_W    = WRAP_W + 1;
    localparam int TURN_W     = 16;
    localparam int POS_W      = 45;
    localparam int SETTLE_W   = 4;
    localparam int TOL_W      = 29;
    localparam int MU_W       = 24;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 29;

    // output beat layout, lowest bit first
    localparam int OUT_TURNS_LSB = POS_W;
    localparam int OUT_PV_BIT    = POS_W + TURN_W;
    localparam int OUT_BUSY_BIT  = OUT_PV_BIT + 1;
    localparam int OUT_SETTL_BIT = OUT_PV_BIT + 2;
    localparam int OUT_OK_BIT    = OUT_PV_BIT + 3;
    localparam int OUT_USED_W    = OUT_OK_BIT + 1;
    localparam int OUT_DATA_W    = ((OUT_USED_W + 7) / 8) * 8;

    // homing accumulator and offset divider (sum / HOMING_SAMPLES in two halves)
    localparam int CNT_W    = $clog2(HOMING_SAMPLES + 1);
    localparam int SUM_W    = RAW_W + CNT_W;
    localparam int DIV_LO_W = SUM_W / 2;
    localparam int DIV_HI_W = SUM_W - DIV_LO_W;
    localparam int DIV_K1   = DIV_HI_W + 6;
    localparam int DIV_K2   = DIV_LO_W + 12;
    localparam int DIV_Y_W  = CNT_W + DIV_LO_W;
    localparam int DIV_P1_W = DIV_HI_W + DIV_K1 + 1;
    localparam int DIV_P2_W = DIV_Y_W + DIV_K2 + 1;

    localparam logic [DIV_K1:0] DIV_R1 = (DIV_K1 + 1)'(
        ((64'd1 << DIV_K1) + 64'(HOMING_SAMPLES) - 64'd1) / 64'(HOMING_SAMPLES));
    localparam logic [DIV_K2:0] DIV_R2 = (DIV_K2 + 1)'(
        ((64'd1 << DIV_K2) + 64'(HOMING_SAMPLES) - 64'd1) / 64'(HOMING_SAMPLES));
    localparam logic [DIV_HI_W-1:0] DIV_N_HI    = DIV_HI_W'(HOMING_SAMPLES);
    localparam logic [CNT_W-1:0]    SAMPLE_LAST = CNT_W'(HOMING_SAMPLES - 1);

    // angle constants in micro-degrees
    localparam logic [19:0]              MICRO_PER_DEG = 20'd1000000;
    localparam logic [WRAP_W-1:0]        FULL_TURN     = WRAP_W'(360000000);
    localparam logic signed [REM_W-1:0]  FULL_TURN_R   = REM_W'(360000000);
    localparam logic signed [DELTA_W-1:0] HALF_TURN_D  = DELTA_W'(180000000);

    // turn quotient estimate: floor(v / 360e6) ~ (v[33:24] * 1527) >>> 15
    localparam int EST_IN_W  = 10;
    localparam int EST_C_W   = 12;
    localparam int EST_P_W   = EST_IN_W + EST_C_W;
    localparam int EST_SHIFT = 15;
    localparam int Q_EST_W   = EST_P_W - EST_SHIFT;
    localparam logic signed [EST_C_W-1:0] WRAP_EST_MUL = 12'sd1527;

    localparam logic signed [TURN_W-1:0] TURN_MIN = {1'b1, {(TURN_W - 1){1'b0}}};
    localparam logic signed [TURN_W-1:0] TURN_MAX = {1'b0, {(TURN_W - 1){1'b1}}};
    localparam logic signed [TURN_W-1:0] TURN_NEG_ONE = {TURN_W{1'b1}};

    localparam logic [SETTLE_W-1:0] SETTLE_TICKS_RST = 4'd5;
    localparam logic [TOL_W-1:0]    VERIFY_TOL_RST   = TOL_W'(1000000);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SETTLE_TICKS = 1'b0,
        REG_VERIFY_TOL   = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic homed;
        logic busy;
        logic settling;
    } status_t;

    typedef struct packed {
        logic                  restart;
        logic                  sample;
        logic signed [V_W-1:0] v;
        status_t               st;
    } front_t;

    typedef struct packed {
        logic              restart;
        logic              sample;
        logic [WRAP_W-1:0] w;
        status_t           st;
    } wrap_t;

    typedef struct packed {
        logic                     sample;
        logic [WRAP_W-1:0]        w;
        logic signed [TURN_W-1:0] turns;
        status_t                  st;
    } turn_t;

endpackage

FILE: rtl/mat_front.sv
module mat_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic                               op,
    input  logic signed [mat_pkg::RAW_W-1:0]   raw_position,
    input  logic [mat_pkg::SETTLE_W-1:0]       settle_ticks,
    output logic                               out_valid,
    input  logic                               out_ready,
    output mat_pkg::front_t                    out_beat
);
    import mat_pkg::*;

    typedef enum logic [2:0] {
        DIV_IDLE   = 3'b001,
        DIV_SPLIT  = 3'b010,
        DIV_FINISH = 3'b100
    } div_state_t;

    div_state_t div_state_reg, div_state_next;

    logic                    valid_reg, valid_next;
    front_t                  beat_reg, beat_next;
    logic                    homed_reg, homed_next;
    logic [SETTLE_W-1:0]     settle_reg, settle_next;
    logic                    collecting_reg, collecting_next;
    logic [CNT_W-1:0]        collected_reg, collected_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [RAW_W-1:0] offset_reg, offset_next;

    logic [DIV_HI_W-1:0] qh_reg;
    logic [CNT_W-1:0]    rh_reg;
    logic [DIV_LO_W-1:0] ml_reg;
    logic                neg_reg;

    logic                  accept;
    logic                  div_start;
    logic [SETTLE_W-1:0]   settle_dec;
    logic [MU_W-1:0]       settle_prod;
    logic signed [V_W-1:0] raw_ext, off_ext, settle_ext, v_calc;

    logic [SUM_W-1:0]    sum_mag;
    logic [DIV_HI_W-1:0] mh, qh, rem_hi;
    logic [DIV_LO_W-1:0] ml, ql;
    logic [DIV_P1_W-1:0] p1;
    logic [DIV_Y_W-1:0]  y;
    logic [DIV_P2_W-1:0] p2;
    logic [SUM_W-1:0]    quot, off_full;

    assign s_tready  = (!valid_reg || out_ready) && (div_state_reg == DIV_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

    // angle before wrapping: raw - offset + countdown in whole degrees
    assign settle_dec  = (settle_reg != '0) ? settle_reg - 1'b1 : '0;
    assign settle_prod = MU_W'(settle_dec) * MU_W'(MICRO_PER_DEG);
    assign raw_ext     = V_W'(raw_position);
    assign off_ext     = V_W'(offset_reg);
    assign settle_ext  = $signed(V_W'(settle_prod));
    assign v_calc      = raw_ext - off_ext + settle_ext;

    always_comb begin
        homed_next      = homed_reg;
        settle_next     = settle_reg;
        collecting_next = collecting_reg;
        collected_next  = collected_reg;
        sum_next        = sum_reg;
        div_start       = 1'b0;
        if (accept) begin
            if (op) begin
                collecting_next = 1'b1;
                collected_next  = '0;
                sum_next        = '0;
            end else begin
                settle_next = settle_dec;
                if (collecting_reg) begin
                    sum_next = sum_reg + SUM_W'(raw_position);
                    if (collected_reg == SAMPLE_LAST) begin
                        homed_next      = 1'b1;
                        settle_next     = settle_ticks;
                        collecting_next = 1'b0;
                        collected_next  = '0;
                        div_start       = 1'b1;
                    end else begin
                        collected_next = collected_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        beat_next.restart     = op;
        beat_next.sample      = !op && homed_reg;
        beat_next.v           = v_calc;
        beat_next.st.homed    = homed_next;
        beat_next.st.busy     = collecting_next;
        beat_next.st.settling = settle_next != '0;
        if (accept) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    // offset = trunc(sum / N): high half first, remainder folded into the low half
    assign sum_mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign mh      = sum_mag[SUM_W-1 -: DIV_HI_W];
    assign ml      = sum_mag[DIV_LO_W-1:0];
    assign p1      = DIV_P1_W'(mh) * DIV_P1_W'(DIV_R1);
    assign qh      = p1[DIV_K1 +: DIV_HI_W];
    assign rem_hi  = mh - qh * DIV_N_HI;

    assign y        = {rh_reg, ml_reg};
    assign p2       = DIV_P2_W'(y) * DIV_P2_W'(DIV_R2);
    assign ql       = p2[DIV_K2 +: DIV_LO_W];
    assign quot     = {qh_reg, ql};
    assign off_full = neg_reg ? -quot : quot;

    always_comb begin
        div_state_next = div_state_reg;
        offset_next    = offset_reg;
        unique case (div_state_reg)
            DIV_IDLE: begin
                if (div_start) begin
                    div_state_next = DIV_SPLIT;
                end
            end
            DIV_SPLIT: begin
                div_state_next = DIV_FINISH;
            end
            DIV_FINISH: begin
                div_state_next = DIV_IDLE;
                offset_next    = $signed(off_full[RAW_W-1:0]);
            end
            default: begin
                div_state_next = DIV_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_state_reg  <= DIV_IDLE;
            valid_reg      <= 1'b0;
            homed_reg      <= 1'b0;
            settle_reg     <= '0;
            collecting_reg <= 1'b0;
            collected_reg  <= '0;
            sum_reg        <= '0;
            offset_reg     <= '0;
        end else begin
            div_state_reg  <= div_state_next;
            valid_reg      <= valid_next;
            homed_reg      <= homed_next;
            settle_reg     <= settle_next;
            collecting_reg <= collecting_next;
            collected_reg  <= collected_next;
            sum_reg        <= sum_next;
            offset_reg     <= offset_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            beat_reg <= beat_next;
        end
        if (div_state_reg == DIV_SPLIT) begin
            qh_reg  <= qh;
            rh_reg  <= rem_hi[CNT_W-1:0];
            ml_reg  <= ml;
            neg_reg <= sum_reg[SUM_W-1];
        end
    end

endmodule

FILE: rtl/mat_wrap.sv
module mat_wrap (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  mat_pkg::front_t in_beat,
    output logic            out_valid,
    input  logic            out_ready,
    output mat_pkg::wrap_t  out_beat
);
    import mat_pkg::*;

    logic   valid_reg, valid_next;
    wrap_t  beat_reg, beat_next;
    logic   load;

    logic signed [EST_IN_W-1:0] v_top;
    logic signed [EST_P_W-1:0]  est_prod;
    logic signed [Q_EST_W-1:0]  q_est;
    logic signed [REM_W-1:0]    q_full, rem, w_sel;

    assign in_ready  = !valid_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

    // estimate may be one off either way; a single fix-up lands in 0..360 degrees
    assign v_top    = in_beat.v[V_W-1 -: EST_IN_W];
    assign est_prod = EST_P_W'(v_top) * EST_P_W'(WRAP_EST_MUL);
    assign q_est    = $signed(est_prod[EST_P_W-1:EST_SHIFT]);
    assign q_full   = REM_W'(q_est) * FULL_TURN_R;
    assign rem      = REM_W'(in_beat.v) - q_full;

    always_comb begin
        if (rem < 0) begin
            w_sel = rem + FULL_TURN_R;
        end else if (rem >= FULL_TURN_R) begin
            w_sel = rem - FULL_TURN_R;
        end else begin
            w_sel = rem;
        end
        beat_next.restart = in_beat.restart;
        beat_next.sample  = in_beat.sample;
        beat_next.w       = w_sel[WRAP_W-1:0];
        beat_next.st      = in_beat.st;
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            beat_reg <= beat_next;
        end
    end

endmodule

FILE: rtl/mat_turns.sv
module mat_turns (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  mat_pkg::wrap_t in_beat,
    output logic           out_valid,
    input  logic           out_ready,
    output mat_pkg::turn_t out_beat
);
    import mat_pkg::*;

    logic                     valid_reg, valid_next;
    turn_t                    beat_reg, beat_next;
    logic [WRAP_W-1:0]        wnow_reg, wnow_next;
    logic                     wnow_valid_reg, wnow_valid_next;
    logic signed [TURN_W-1:0] turn_reg, turn_next;
    logic                     load;
    logic signed [DELTA_W-1:0] delta;

    assign in_ready  = !valid_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

    assign delta = $signed({1'b0, in_beat.w}) - $signed({1'b0, wnow_reg});

    always_comb begin
        wnow_next       = wnow_reg;
        wnow_valid_next = wnow_valid_reg;
        turn_next       = turn_reg;
        if (load) begin
            if (in_beat.restart) begin
                wnow_valid_next = 1'b0;
                turn_next       = '0;
            end else if (in_beat.sample) begin
                wnow_next       = in_beat.w;
                wnow_valid_next = 1'b1;
                // exactly half a turn counts as no wrap
                if (wnow_valid_reg) begin
                    if (delta > HALF_TURN_D) begin
                        if (turn_reg != TURN_MIN) begin
                            turn_next = turn_reg - 1'b1;
                        end
                    end else if (delta < -HALF_TURN_D) begin
                        if (turn_reg != TURN_MAX) begin
                            turn_next = turn_reg + 1'b1;
                        end
                    end
                end
            end
        end
        beat_next.sample = in_beat.sample;
        beat_next.w      = in_beat.w;
        beat_next.turns  = turn_next;
        beat_next.st     = in_beat.st;
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= 1'b0;
            wnow_reg       <= '0;
            wnow_valid_reg <= 1'b0;
            turn_reg       <= '0;
        end else begin
            valid_reg      <= valid_next;
            wnow_reg       <= wnow_next;
            wnow_valid_reg <= wnow_valid_next;
            turn_reg       <= turn_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            beat_reg <= beat_next;
        end
    end

endmodule

FILE: rtl/mat_out.sv
module mat_out (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  mat_pkg::turn_t                   in_beat,
    input  logic [mat_pkg::TOL_W-1:0]        verify_tolerance,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [mat_pkg::POS_W-1:0] position,
    output logic signed [mat_pkg::TURN_W-1:0] turns,
    output mat_pkg::status_t                 status,
    output logic                             homing_ok
);
    import mat_pkg::*;

    logic                     valid_reg, valid_next;
    logic signed [POS_W-1:0]  held_reg, held_next;
    logic signed [TURN_W-1:0] turns_reg;
    status_t                  st_reg;
    logic                     ok_reg, ok_next;
    logic                     load;

    logic signed [POS_W-1:0] turn_prod, held_calc, tol_s;

    assign in_ready  = !valid_reg || m_ready;
    assign load      = in_valid && in_ready;
    assign m_valid   = valid_reg;
    assign position  = held_reg;
    assign turns     = turns_reg;
    assign status    = st_reg;
    assign homing_ok = ok_reg;

    assign turn_prod = POS_W'(in_beat.turns) * $signed(POS_W'(FULL_TURN));
    assign held_calc = $signed(POS_W'(in_beat.w)) + turn_prod;
    assign tol_s     = $signed(POS_W'(verify_tolerance));

    always_comb begin
        held_next = (load && in_beat.sample) ? held_calc : held_reg;
        ok_next   = in_beat.st.homed && (held_next <= tol_s) && (held_next >= -tol_s) &&
                    !(held_next < 0 && in_beat.turns != TURN_NEG_ONE);
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            held_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            held_reg  <= held_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            turns_reg <= in_beat.turns;
            st_reg    <= in_beat.st;
            ok_reg    <= ok_next;
        end
    end

endmodule

FILE: rtl/multiturn_angle_tracker_core.sv
// Multi-turn angle tracker.
// Input beats: s_tdata carries a signed raw angle in micro-degrees, s_tuser[0]
// selects a sample (0) or a start-homing command (1). After a start command the
// next HOMING_SAMPLES samples are averaged into the zero offset; once homed each
// sample is wrapped into 0..360 degrees and unwrapped with a saturating turn count.
// Every input beat gives exactly one output beat on m_*.
// An s_ beat reaches m_tvalid through the front, wrap, turn count and output
// registers. Throughput is one beat per cycle while m_tready allows; after the
// beat that completes homing, s_tready stays low while the two-step offset
// divider runs.
// Each stage holds its own beat, so a stalled m_tready fills the four stages and
// only then drops s_tready. Results are never dropped or repeated.
// Reset (aresetn low, synchronous) empties the pipe, clears homing state, offset
// and turn count, and loads settle_ticks = 5, verify_tolerance = 1000000.
// Configuration writes (cfg_wr_en) take effect at the next edge and are meant to
// happen while the block is empty.
module multiturn_angle_tracker_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [31:0]                         s_tdata,   // [31:0] raw_position
    input  logic [0:0]                          s_tuser,   // [0] op
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [44:0] position, [60:45] turns, [61] position_valid, [62] homing_busy,
    // [63] settling, [64] homing_ok, rest zero
    output logic [mat_pkg::OUT_DATA_W-1:0]      m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [mat_pkg::CFG_ADDR_W-1:0]      cfg_index,
    input  logic [mat_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import mat_pkg::*;

    logic [SETTLE_W-1:0] settle_ticks_reg;
    logic [TOL_W-1:0]    verify_tol_reg;

    logic   f_valid, f_ready;
    front_t f_beat;
    logic   w_valid, w_ready;
    wrap_t  w_beat;
    logic   t_valid, t_ready;
    turn_t  t_beat;

    logic signed [POS_W-1:0]  position;
    logic signed [TURN_W-1:0] turns;
    status_t                  status;
    logic                     homing_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_ticks_reg <= SETTLE_TICKS_RST;
            verify_tol_reg   <= VERIFY_TOL_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SETTLE_TICKS: settle_ticks_reg <= cfg_wdata[SETTLE_W-1:0];
                REG_VERIFY_TOL:   verify_tol_reg   <= cfg_wdata[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    mat_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .op           (s_tuser[0]),
        .raw_position ($signed(s_tdata[RAW_W-1:0])),
        .settle_ticks (settle_ticks_reg),
        .out_valid    (f_valid),
        .out_ready    (f_ready),
        .out_beat     (f_beat)
    );

    mat_wrap u_wrap (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_beat   (f_beat),
        .out_valid (w_valid),
        .out_ready (w_ready),
        .out_beat  (w_beat)
    );

    mat_turns u_turns (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (w_valid),
        .in_ready  (w_ready),
        .in_beat   (w_beat),
        .out_valid (t_valid),
        .out_ready (t_ready),
        .out_beat  (t_beat)
    );

    mat_out u_out (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (t_valid),
        .in_ready         (t_ready),
        .in_beat          (t_beat),
        .verify_tolerance (verify_tol_reg),
        .m_valid          (m_tvalid),
        .m_ready          (m_tready),
        .position         (position),
        .turns            (turns),
        .status           (status),
        .homing_ok        (homing_ok)
    );

    assign m_tdata = {{(OUT_DATA_W - OUT_USED_W){1'b0}}, homing_ok, status.settling,
                      status.busy, status.homed, turns, position};

endmodule

FILE: rtl/mat_checker.sv
module mat_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [mat_pkg::OUT_DATA_W-1:0] m_tdata
);
    import mat_pkg::*;

    logic [POS_W-1:0]  pos_f;
    logic [TURN_W-1:0] turns_f;
    logic              pv_f, settling_f, ok_f;

    assign pos_f      = m_tdata[POS_W-1:0];
    assign turns_f    = m_tdata[OUT_TURNS_LSB +: TURN_W];
    assign pv_f       = m_tdata[OUT_PV_BIT];
    assign settling_f = m_tdata[OUT_SETTL_BIT];
    assign ok_f       = m_tdata[OUT_OK_BIT];

    // before the first homing completes nothing may leak into position or turns
    a_unhomed_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !pv_f |-> pos_f == '0 && turns_f == '0)
        else $error("unhomed beat carries nonzero position or turns");

    a_ok_needs_homed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ok_f |-> pv_f)
        else $error("homing_ok set while not homed");

    // the countdown is only ever loaded when homing completes
    a_settle_needs_homed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && settling_f |-> pv_f)
        else $error("settling set while not homed");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

endmodule

bind multiturn_angle_tracker_core mat_checker u_mat_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: sim/tracker_checker.sv
`timescale 1ns / 1ps

package tracker_tb_pkg;

    typedef enum logic [0:0] {
        OP_SAMPLE = 1'b0,
        OP_HOME   = 1'b1
    } track_op_t;

    localparam longint      UDEG_PER_DEG   = 1_000_000;
    localparam longint      UDEG_PER_TURN  = 360_000_000;
    localparam longint      UDEG_HALF_TURN = 180_000_000;
    localparam int unsigned TOL_MAX        = 360_000_000;

endpackage

module tracker_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [31:0]                    s_tdata,
    input  logic [0:0]                     s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [mat_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                           cfg_wr_en,
    input  logic [mat_pkg::CFG_ADDR_W-1:0] cfg_index,
    input  logic [mat_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                             mismatches,
    output int                             outstanding
);
    import mat_pkg::*;
    import tracker_tb_pkg::*;

    typedef struct packed {
        logic signed [POS_W-1:0]  position;
        logic signed [TURN_W-1:0] turns;
        logic                     pos_valid;
        logic                     homing_busy;
        logic                     settling;
        logic                     homing_ok;
    } track_out_t;

    logic [SETTLE_W-1:0] settle_ticks_cfg;
    logic [TOL_W-1:0]    tol_cfg;

    logic signed [31:0]  zero_ofs;
    logic                homed;
    logic [SETTLE_W-1:0] settle_cnt;
    longint              wrap_cur;
    logic                wrap_cur_ok;
    longint              wrap_last;
    logic                wrap_last_ok;
    int                  turn_cnt;
    longint              held_pos;
    logic                collecting;
    int                  n_taken;
    longint              raw_sum;

    track_out_t pending_reports[$];

    function automatic track_out_t advance_tracker(input track_op_t op,
                                                   input logic signed [31:0] raw);
        longint     v;
        longint     d;
        longint     mag;
        track_out_t r;
        if (op == OP_HOME) begin
            wrap_cur_ok  = 1'b0;
            wrap_last_ok = 1'b0;
            turn_cnt     = 0;
            collecting   = 1'b1;
            n_taken      = 0;
            raw_sum      = 0;
        end else begin
            if (settle_cnt != 0)
                settle_cnt = settle_cnt - 1'b1;
            if (homed) begin
                v = longint'(raw) - longint'(zero_ofs) + longint'(settle_cnt) * UDEG_PER_DEG;
                v = v % UDEG_PER_TURN;
                if (v < 0)
                    v = v + UDEG_PER_TURN;
                wrap_last    = wrap_cur;
                wrap_last_ok = wrap_cur_ok;
                wrap_cur     = v;
                wrap_cur_ok  = 1'b1;
                if (wrap_last_ok) begin
                    d = wrap_cur - wrap_last;
                    // forward wrap past zero counts up, backward counts down
                    if (d > UDEG_HALF_TURN) begin
                        if (turn_cnt > int'(TURN_MIN))
                            turn_cnt--;
                    end else if (d < -UDEG_HALF_TURN) begin
                        if (turn_cnt < int'(TURN_MAX))
                            turn_cnt++;
                    end
                end
                held_pos = wrap_cur + longint'(turn_cnt) * UDEG_PER_TURN;
            end
            // the closing sample was processed above with the old offset
            if (collecting) begin
                raw_sum = raw_sum + longint'(raw);
                n_taken++;
                if (n_taken >= HOMING_SAMPLES) begin
                    zero_ofs   = 32'(raw_sum / HOMING_SAMPLES);
                    homed      = 1'b1;
                    settle_cnt = settle_ticks_cfg;
                    collecting = 1'b0;
                end
            end
        end
        mag           = (held_pos < 0) ? -held_pos : held_pos;
        r.position    = held_pos[POS_W-1:0];
        r.turns       = turn_cnt[TURN_W-1:0];
        r.pos_valid   = homed;
        r.homing_busy = collecting;
        r.settling    = (settle_cnt != 0);
        r.homing_ok   = homed && (mag <= longint'(tol_cfg)) && !(held_pos < 0 && turn_cnt != -1);
        return r;
    endfunction

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] seen);
        if (seen !== want) begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        track_out_t want;
        if (!aresetn) begin
            settle_ticks_cfg = SETTLE_TICKS_RST;
            tol_cfg          = VERIFY_TOL_RST;
            zero_ofs         = '0;
            homed            = 1'b0;
            settle_cnt       = '0;
            wrap_cur         = 0;
            wrap_cur_ok      = 1'b0;
            wrap_last        = 0;
            wrap_last_ok     = 1'b0;
            turn_cnt         = 0;
            held_pos         = 0;
            collecting       = 1'b0;
            n_taken          = 0;
            raw_sum          = 0;
            mismatches       = 0;
            pending_reports.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == REG_SETTLE_TICKS)
                    settle_ticks_cfg = cfg_wdata[SETTLE_W-1:0];
                else if (cfg_index == REG_VERIFY_TOL)
                    tol_cfg = cfg_wdata[TOL_W-1:0];
            end
            if (m_tvalid && m_tready) begin
                if (pending_reports.size() == 0) begin
                    $error("result beat with nothing expected: tdata=%h", m_tdata);
                    mismatches++;
                end else begin
                    want = pending_reports.pop_front();
                    check_field("position", want.position, $signed(m_tdata[POS_W-1:0]));
                    check_field("turns", want.turns,
                                $signed(m_tdata[OUT_TURNS_LSB +: TURN_W]));
                    check_field("position_valid", want.pos_valid, m_tdata[OUT_PV_BIT]);
                    check_field("homing_busy", want.homing_busy, m_tdata[OUT_BUSY_BIT]);
                    check_field("settling", want.settling, m_tdata[OUT_SETTL_BIT]);
                    check_field("homing_ok", want.homing_ok, m_tdata[OUT_OK_BIT]);
                    check_field("padding", 0, m_tdata[OUT_DATA_W-1:OUT_USED_W]);
                end
            end
            if (s_tvalid && s_tready)
                pending_reports.insert(pending_reports.size(),
                                       advance_tracker(track_op_t'(s_tuser),
                                                       $signed(s_tdata)));
        end
        outstanding = pending_reports.size();
    end

endmodule

FILE: sim/multiturn_angle_tracker_core_test.sv
`timescale 1ns / 1ps

module multiturn_angle_tracker_core_test;
    import mat_pkg::*;
    import tracker_tb_pkg::*;

    localparam int     GAP_MAX       = 6;
    localparam int     PHASE_ITEMS   = 150;
    localparam int     SAT_SAMPLES   = 60;
    localparam longint SAT_BASE      = 100_000_000;
    localparam longint CYCLE_LIMIT   = 100_000;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_COMB, RX_CHOKE} rx_mode_t;
    typedef enum logic [1:0] {STEP_CREEP, STEP_SWING, STEP_LEAP, STEP_HALF} step_kind_t;

    logic                  aclk       = 1'b0;
    logic                  aresetn    = 1'b0;
    logic                  s_tvalid   = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata    = '0;
    logic [0:0]            s_tuser    = '0;
    logic                  m_tvalid;
    logic                  m_tready   = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_wr_en  = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
    int                    mismatches;
    int                    outstanding;

    logic     steady     = 1'b0;
    rx_mode_t rx_mode    = RX_OPEN;
    int       rx_left    = 0;
    longint   cycle_cnt  = 0;
    int       burst_left = 0;
    int       items_sent = 0;

    multiturn_angle_tracker_core i_dut (.*);

    tracker_checker i_checker (.*);

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side backpressure; the mode is redrawn whenever rx_left runs out
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= steady ? rx_mode_t'($urandom_range(0, 1)) : rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(8, 160);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:  m_tready <= 1'b1;
            RX_COIN:  m_tready <= ($urandom_range(0, 3) != 0);
            RX_COMB:  m_tready <= (cycle_cnt % 5 != 2) && (cycle_cnt % 7 != 3);
            default:  m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    task automatic send_beat(input track_op_t op, input logic [31:0] raw);
        logic took;
        if (burst_left == 0) begin
            if (!steady) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, GAP_MAX)) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= raw;
        s_tuser  <= op;
        do begin
            @(negedge aclk);
            took = s_tready;
            @(posedge aclk);
        end while (!took);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        burst_left = 0;
        do @(negedge aclk); while (outstanding != 0);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic set_config(input logic [SETTLE_W-1:0] settle, input logic [TOL_W-1:0] tol);
        wait_drained();
        // let the offset divider finish before touching registers
        repeat (8) @(posedge aclk);
        write_reg(REG_SETTLE_TICKS, CFG_DATA_W'(settle));
        write_reg(REG_VERIFY_TOL, CFG_DATA_W'(tol));
        cfg_wr_en <= 1'b0;
    endtask

    function automatic longint jitter(input longint span);
        return longint'($urandom_range(0, 32'(2 * span))) - span;
    endfunction

    // start homing, collect the samples, then follow a moving angle
    task automatic homing_run();
        longint     center;
        longint     angle;
        longint     spread;
        longint     step;
        int         taken;
        int         n;
        step_kind_t kind;
        center = longint'($urandom_range(0, 2_000_000_000)) - 1_000_000_000;
        case ($urandom_range(0, 3))
            0:       spread = 0;
            1:       spread = 1000;
            2:       spread = 2_000_000;
            default: spread = 60_000_000;
        endcase
        send_beat(OP_HOME, $urandom);
        taken = 0;
        while (taken < HOMING_SAMPLES) begin
            if ($urandom_range(0, 39) == 0) begin
                send_beat(OP_HOME, $urandom);
                taken = 0;
            end else begin
                send_beat(OP_SAMPLE, 32'(center + jitter(spread)));
                taken++;
            end
        end
        kind  = step_kind_t'($urandom_range(0, 3));
        n     = $urandom_range(4, 60);
        angle = center;
        repeat (n) begin
            case (kind)
                STEP_CREEP: step = jitter(1_500_000);
                STEP_SWING: step = jitter(120_000_000);
                STEP_LEAP:  step = longint'($urandom_range(170_000_000, 230_000_000));
                default:    step = UDEG_HALF_TURN;
            endcase
            if (kind != STEP_CREEP && kind != STEP_SWING && $urandom_range(0, 1))
                step = -step;
            angle = angle + step;
            send_beat(OP_SAMPLE, 32'(angle));
        end
    endtask

    task automatic noise_burst();
        track_op_t op;
        repeat ($urandom_range(1, 10)) begin
            op = ($urandom_range(0, 7) == 0) ? OP_HOME : OP_SAMPLE;
            send_beat(op, $urandom);
        end
    endtask

    initial begin
        int     stop_at;
        longint spin;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_config(4'd0, TOL_W'(TOL_MAX));
        send_beat(OP_HOME, 32'hFFFF_FFFF);
        send_beat(OP_SAMPLE, 32'h1234_5678);
        send_beat(OP_HOME, 32'h0000_0000);
        // extremes alternate: sum is -10, average must truncate toward zero
        for (int i = 0; i < HOMING_SAMPLES; i++)
            send_beat(OP_SAMPLE, i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF);
        send_beat(OP_SAMPLE, 32'd180_000_000);
        send_beat(OP_SAMPLE, 32'd0);
        send_beat(OP_SAMPLE, 32'd359_000_000);
        send_beat(OP_SAMPLE, 32'h7FFF_FFFF);
        send_beat(OP_SAMPLE, 32'h8000_0000);

        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0:       set_config(4'd0, TOL_W'(0));
                1:       set_config(4'd15, TOL_W'(TOL_MAX));
                2:       set_config(SETTLE_TICKS_RST, VERIFY_TOL_RST);
                3:       set_config(4'd15, TOL_W'(0));
                4:       set_config(4'd0, TOL_W'(TOL_MAX));
                default: set_config(4'($urandom_range(0, 15)),
                                    TOL_W'($urandom_range(0, TOL_MAX)));
            endcase
            stop_at = items_sent + PHASE_ITEMS;
            while (items_sent < stop_at) begin
                if ($urandom_range(0, 4) != 0)
                    homing_run();
                else
                    noise_burst();
            end
        end

        // spin steadily each way, just under half a turn per beat
        set_config(4'd0, TOL_W'(TOL_MAX));
        steady <= 1'b1;
        for (int dir = -1; dir <= 1; dir += 2) begin
            send_beat(OP_HOME, 32'h0000_0000);
            for (int i = 0; i < HOMING_SAMPLES; i++)
                send_beat(OP_SAMPLE, 32'(SAT_BASE));
            spin = 0;
            for (int k = 0; k < SAT_SAMPLES; k++) begin
                spin = spin + dir * longint'($urandom_range(170_000_000, 179_999_999));
                if (spin < 0)
                    spin = spin + UDEG_PER_TURN;
                else if (spin >= UDEG_PER_TURN)
                    spin = spin - UDEG_PER_TURN;
                send_beat(OP_SAMPLE, 32'(SAT_BASE + spin));
            end
        end
        steady <= 1'b0;

        wait_drained();
        repeat (16) @(posedge aclk);
        @(negedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
